// File: hdl/saturating_matrix_multiply_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the saturating matrix multiply unit
// Shared clocked forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef SATURATING_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SATURATING_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SMMU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smmu check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define SMMU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smmu check failed");

`endif

// File: hdl/smmu_pkg.sv
// ---------------------------------------------------------------------------
// smmu_pkg
// Types and constants shared by the matrix multiply controller and datapath.
// ---------------------------------------------------------------------------
package smmu_pkg;

    localparam int VAL_W = 8;                       // element width
    localparam int IDX_W = 3;                       // row, column and k index width
    localparam logic [VAL_W-1:0] SAT_MAX = 8'd255;  // clamp value

    typedef enum logic [1:0] {
        ST_LOAD,    // taking element pairs
        ST_ISSUE,   // issuing k = 0 .. DIM-1 reads for one cell
        ST_DRAIN,   // waiting for the MAC pipe to empty
        ST_EMIT     // handing the cell to the output register
    } t_state;

    typedef struct packed {
        logic             load;       // store an element pair
        logic             load_last;  // pair closes the load
        logic             issue;      // read A[row][k] and B[k][col]
        logic             first;      // first read of a cell, clears the sum
        logic             emit;       // copy the sum to the output register
        logic             last_cell;  // emitted cell is the final one
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;  // products still on their way to the sum
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

    function automatic logic [VAL_W-1:0] sat_mul(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] y);
        logic [2*VAL_W-1:0] p;
        p = x * y;
        return (|p[2*VAL_W-1:VAL_W]) ? SAT_MAX : p[VAL_W-1:0];
    endfunction

endpackage

// File: hdl/smmu_ram.sv
// ---------------------------------------------------------------------------
// smmu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module smmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                    i_wr_data,
    input  logic                                i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                    o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/smmu_datapath.sv
// ---------------------------------------------------------------------------
// smmu_datapath
// Element stores, load counter, MAC pipe with saturation, output register.
// ---------------------------------------------------------------------------
module smmu_datapath
    import smmu_pkg::*;
#(
    parameter int DIM = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [VAL_W-1:0]   i_a_value,
    input  logic [VAL_W-1:0]   i_b_value,
    input  logic               i_out_ready,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic [VAL_W-1:0]   o_c_value,
    output logic [IDX_W-1:0]   o_row_index,
    output logic [IDX_W-1:0]   o_col_index,
    output logic               o_result_last
);

    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W  = $clog2(CELLS + 1);

    // load position, saturates at CELLS
    logic [CNT_W-1:0]   r_load_count, n_load_count;
    logic               w_load_wr;

    logic [ADDR_W-1:0]  w_a_rd_addr, w_b_rd_addr;
    logic [VAL_W-1:0]   w_a_rd_data, w_b_rd_data;

    // MAC pipe: s1 = store data ready, s2 = clamped product ready
    logic               r_s1_valid, r_s2_valid;
    logic [VAL_W-1:0]   r_prod;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic [VAL_W:0]     w_sum;

    logic               r_out_valid;
    logic [VAL_W-1:0]   r_c_value;
    logic [IDX_W-1:0]   r_row_index, r_col_index;
    logic               r_result_last;

    assign w_load_wr = i_cmd.load && (r_load_count < CNT_W'(CELLS));

    always_comb begin
        n_load_count = r_load_count;
        if (i_cmd.load) begin
            if (i_cmd.load_last) begin
                n_load_count = '0;
            end else if (w_load_wr) begin
                n_load_count = CNT_W'(r_load_count + 1'b1);
            end
        end
    end

    assign w_a_rd_addr = ADDR_W'(int'(i_cmd.row) * DIM + int'(i_cmd.k));
    assign w_b_rd_addr = ADDR_W'(int'(i_cmd.k) * DIM + int'(i_cmd.col));

    smmu_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_a_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load_wr),
        .i_wr_addr (r_load_count[ADDR_W-1:0]),
        .i_wr_data (i_a_value),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (w_a_rd_addr),
        .o_rd_data (w_a_rd_data)
    );

    smmu_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_b_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load_wr),
        .i_wr_addr (r_load_count[ADDR_W-1:0]),
        .i_wr_data (i_b_value),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (w_b_rd_addr),
        .o_rd_data (w_b_rd_data)
    );

    assign w_sum = {1'b0, r_acc} + {1'b0, r_prod};

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.issue && i_cmd.first) begin
            n_acc = '0;
        end else if (r_s2_valid) begin
            n_acc = w_sum[VAL_W] ? SAT_MAX : w_sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_load_count <= n_load_count;
            r_s1_valid   <= i_cmd.issue;
            r_s2_valid   <= r_s1_valid;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= sat_mul(w_a_rd_data, w_b_rd_data);
        r_acc  <= n_acc;
        if (i_cmd.emit) begin
            r_c_value     <= r_acc;
            r_row_index   <= i_cmd.row;
            r_col_index   <= i_cmd.col;
            r_result_last <= i_cmd.last_cell;
        end
    end

    assign o_sts.pipe_busy = r_s1_valid || r_s2_valid;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_c_value     = r_c_value;
    assign o_row_index   = r_row_index;
    assign o_col_index   = r_col_index;
    assign o_result_last = r_result_last;

endmodule

// File: hdl/smmu_controller.sv
// ---------------------------------------------------------------------------
// smmu_controller
// Sequencer: load phase, then one cell at a time over row, column and k.
// ---------------------------------------------------------------------------
module smmu_controller
    import smmu_pkg::*;
#(
    parameter int DIM = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;
    logic             w_accept;
    logic             w_last_cell;

    assign w_accept    = i_in_valid && (r_state == ST_LOAD);
    assign w_last_cell = (r_row == IDX_MAX) && (r_col == IDX_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_in_last) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_k == IDX_MAX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = w_last_cell ? ST_LOAD : ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // cell and k counters
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_k   = r_k;
        case (r_state)
            ST_LOAD: begin
                n_row = '0;
                n_col = '0;
                n_k   = '0;
            end
            ST_ISSUE: begin
                n_k = (r_k == IDX_MAX) ? '0 : IDX_W'(r_k + 1'b1);
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    if (r_col == IDX_MAX) begin
                        n_col = '0;
                        n_row = IDX_W'(r_row + 1'b1);
                    end else begin
                        n_col = IDX_W'(r_col + 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.row       = r_row;
        o_cmd.col       = r_col;
        o_cmd.k         = r_k;
        o_cmd.last_cell = w_last_cell;
        case (r_state)
            ST_LOAD: begin
                o_in_ready      = 1'b1;
                o_cmd.load      = w_accept;
                o_cmd.load_last = i_in_last;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_k == '0);
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

endmodule

// File: hdl/saturating_matrix_multiply_unit.sv
// ---------------------------------------------------------------------------
// saturating_matrix_multiply_unit
// DIM x DIM unsigned 8-bit matrix multiply with saturating products and sums.
//
// Channel   Dir  tdata (low bit up)                 tlast
// s_axis    in   a_value[7:0] b_value[15:8]         load_last
// m_axis    out  c_value[7:0] row[10:8] col[13:11]  result_last
//                zero [15:14]
//
// Cycles: one load transaction per cycle while loading. After the transaction
//   that carries tlast, the DIM*DIM cells are worked one at a time: DIM reads
//   (k = 0 .. DIM-1), a MAC pipe drain and a hand-off to the output register,
//   with no overlap between cells, set by the single shared
//   multiply-accumulate unit and the one read port on each element store.
// Reset: synchronous, active low; clears the sequencer, load counter and
//   valid flags. The element stores are not cleared (no clearing pass).
// Stalls: a held m_axis_tready freezes the sequencer at the next cell hand-off;
//   s_axis_tready is low from the closing load transaction until the last
//   cell has been handed to the output register.
// ---------------------------------------------------------------------------
module saturating_matrix_multiply_unit
    import smmu_pkg::*;
#(
    parameter int DIM = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: element pairs
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // a_value[7:0], b_value[15:8]
    input  logic        s_axis_tlast,   // load_last
    // master side: result elements
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // c_value[7:0], row_index[10:8],
                                        // col_index[13:11], zero[15:14]
    output logic        m_axis_tlast    // result_last
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [VAL_W-1:0] w_c_value;
    logic [IDX_W-1:0] w_row_index;
    logic [IDX_W-1:0] w_col_index;

    // sequencer: load, issue reads per cell, drain, hand off
    smmu_controller #(.DIM(DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // stores, MAC pipe and output register
    smmu_datapath #(.DIM(DIM)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_a_value     (s_axis_tdata[7:0]),
        .i_b_value     (s_axis_tdata[15:8]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_c_value     (w_c_value),
        .o_row_index   (w_row_index),
        .o_col_index   (w_col_index),
        .o_result_last (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_col_index, w_row_index, w_c_value};

endmodule

// File: hdl/smmu_checker.sv
// ---------------------------------------------------------------------------
// smmu_checker
// Port-level checks on the matrix multiply unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "saturating_matrix_multiply_unit_assert.svh"

module smmu_checker #(
    parameter int DIM = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast
);

    localparam logic [3:0] DIM_L  = 4'(DIM);
    localparam logic [2:0] IDX_MX = 3'(DIM - 1);

    // a stalled result holds
    `SMMU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // indices inside the matrix, padding bits zero
    `SMMU_ASSERT_NOW(a_idx_range, m_axis_tvalid,
        (m_axis_tdata[15:14] == 2'b00) && ({1'b0, m_axis_tdata[10:8]} < DIM_L)
        && ({1'b0, m_axis_tdata[13:11]} < DIM_L))

    // tlast exactly on the bottom-right element
    `SMMU_ASSERT_NOW(a_last_pos, m_axis_tvalid,
        m_axis_tlast == ((m_axis_tdata[10:8] == IDX_MX) && (m_axis_tdata[13:11] == IDX_MX)))

    // closing load transaction starts the compute phase
    `SMMU_ASSERT_NEXT(a_busy_after_load, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready)

endmodule

bind saturating_matrix_multiply_unit smmu_checker #(.DIM(DIM)) u_smmu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: dv/tb_saturating_matrix_multiply_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_saturating_matrix_multiply_unit
// Loads element pairs of A and B over the slave stream. Every transaction
// that closes a load is run through a local saturating matrix product, and
// the expected cells are queued. Each cell on the master stream is compared
// with the oldest queued one. A short directed table runs first, then
// random loads: mostly full loads, plus short and overlong ones. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module tb_saturating_matrix_multiply_unit;
    import smmu_pkg::*;

    localparam int DIM = 4;
    localparam int CELLS = DIM * DIM;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned RANDOM_PAIRS = 500;
    localparam int unsigned HOLD_AFTER = 64;    // results seen before the long hold-off
    localparam int unsigned HOLD_CYCLES = 300;

    // one expected or observed element of C
    typedef struct packed {
        logic [VAL_W-1:0] c;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_cell;

    // directed row: a pair repeated reps times, tlast on the final repeat;
    // typed rows carry a hand-worked value for every cell of the product
    typedef struct packed {
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             last;
        logic [4:0]       reps;
        logic             typed;
        logic [VAL_W-1:0] fill;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 8;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // full load of all-ones elements: every product and sum clamps
        '{8'hFF, 8'hFF, 1'b1, 5'd16, 1'b1, SAT_MAX},
        // one-pair load: only position zero is rewritten
        '{8'h00, 8'h00, 1'b1, 5'd1,  1'b0, 8'h00},
        // partial load over the earlier values, alternating bit patterns
        '{8'hAA, 8'h55, 1'b0, 5'd1,  1'b0, 8'h00},
        '{8'h55, 8'hAA, 1'b0, 5'd1,  1'b0, 8'h00},
        '{8'h10, 8'h10, 1'b0, 5'd1,  1'b0, 8'h00},   // product just over the clamp
        '{8'h0F, 8'h11, 1'b0, 5'd1,  1'b0, 8'h00},   // product exactly at the clamp
        '{8'h01, 8'h00, 1'b0, 5'd1,  1'b0, 8'h00},
        '{8'h00, 8'h01, 1'b1, 5'd1,  1'b0, 8'h00}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // a_value[7:0], b_value[15:8]
    logic        s_axis_tlast;     // load_last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // c_value[7:0], row_index[10:8], col_index[13:11], zero[15:14]
    logic        m_axis_tlast;     // result_last

    // local copy of the element stores and the load position
    logic [VAL_W-1:0] a_elems [CELLS];
    logic [VAL_W-1:0] b_elems [CELLS];
    int unsigned      fill_pos;

    t_cell       pending_cells [$];
    int unsigned mismatches;
    int unsigned cycle_count = 0;
    bit          steady;           // no idling on either side while set

    saturating_matrix_multiply_unit #(
        .DIM (DIM)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Store one accepted pair; on tlast, queue every cell of the clamped product.
    task automatic store_pair(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                              input logic last, input logic typed,
                              input logic [VAL_W-1:0] fill);
        int unsigned prod;
        int unsigned acc;
        t_cell       exp_cell;
        if (fill_pos < CELLS) begin
            a_elems[fill_pos] = a;
            b_elems[fill_pos] = b;
            fill_pos++;
        end
        if (last) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    acc = 0;
                    for (int k = 0; k < DIM; k++) begin
                        prod = a_elems[r*DIM + k] * b_elems[k*DIM + c];
                        if (prod > SAT_MAX) prod = SAT_MAX;
                        acc += prod;
                        if (acc > SAT_MAX) acc = SAT_MAX;
                    end
                    exp_cell.c    = typed ? fill : acc[VAL_W-1:0];
                    exp_cell.row  = r[IDX_W-1:0];
                    exp_cell.col  = c[IDX_W-1:0];
                    exp_cell.last = (r == DIM-1) && (c == DIM-1);
                    pending_cells.push_back(exp_cell);
                end
            end
            fill_pos = 0;
        end
    endtask

    // Offer one pair, wait for the transaction, then maybe leave a gap.
    task automatic offer_pair(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                              input logic last, input logic typed,
                              input logic [VAL_W-1:0] fill);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        store_pair(a, b, last, typed, fill);
        if (!steady && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Element values: small ones keep products below the clamp, the rest cover
    // every bit, the extremes and products near the clamp.
    function automatic logic [VAL_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)      return VAL_W'($urandom_range(15));
        else if (r < 70) return VAL_W'($urandom_range(255));
        else if (r < 80) return SAT_MAX;
        else if (r < 90) return '0;
        else             return VAL_W'($urandom_range(16, 64));
    endfunction

    // Receiver: checks each result transaction and drives tready.
    initial begin
        t_cell       got;
        t_cell       want;
        int unsigned results_seen;
        int unsigned hold_left;
        bit          hold_taken;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tdata[13:11],
                        m_axis_tlast};
                results_seen++;
                if (pending_cells.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: c=%0d row=%0d col=%0d last=%0b",
                                 got.c, got.row, got.col, got.last);
                end else begin
                    want = pending_cells.pop_front();
                    if (got != want || m_axis_tdata[15:14] != 2'b00) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected c=%0d row=%0d col=%0d last=%0b",
                                     want.c, want.row, want.col, want.last);
                            $display("          got c=%0d row=%0d col=%0d last=%0b pad=%0b",
                                     got.c, got.row, got.col, got.last,
                                     m_axis_tdata[15:14]);
                        end
                    end
                end
            end
            // one long hold-off so the block fills up and stalls the loader
            if (!hold_taken && results_seen >= HOLD_AFTER) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    // Sender and run control.
    initial begin
        int unsigned stored;
        int unsigned len;
        int unsigned kind;
        t_stim_row   row;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        steady        = 1'b0;
        fill_pos      = 0;
        stored        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part; the first row fills every position, so no entry
        // is ever read before it has been written
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            for (int n = 0; n < row.reps; n++)
                offer_pair(row.a, row.b, row.last && (n == row.reps - 1),
                           row.typed, row.fill);
        end

        // random loads: mostly full, some ending early, some overlong
        while (stored < RANDOM_PAIRS) begin
            kind = $urandom_range(99);
            if (kind < 70)      len = CELLS;
            else if (kind < 85) len = $urandom_range(1, CELLS - 1);
            else                len = $urandom_range(CELLS + 1, CELLS + 4);
            steady = (stored >= 200) && (stored < 300);
            for (int n = 0; n < len; n++) begin
                offer_pair(pick_elem(), pick_elem(), n == len - 1, 1'b0, 8'h00);
                if (n < CELLS) stored++;
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (DIM + 8) @(posedge i_clk);

        if (mismatches == 0 && pending_cells.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
